// ===== rtl/nhvt_pkg.sv =====
// Shared types and constants for the node hierarchy visibility table.
// Holds command codes, field widths and the controller/datapath interface.
// No dependencies.
package nhvt_pkg;

   localparam int MAX_NODES_DEF = 1024;

   localparam int CMD_W    = 3;
   localparam int NODE_W   = 10;
   localparam int PARENT_W = 11;
   localparam int CFG_W    = 11;
   localparam int DESC_W   = 10;
   localparam int VCOUNT_W = 11;

   localparam logic [DESC_W-1:0] DESC_MAX = 10'd1023;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR         = 3'd0,
      CMD_SET_PARENT    = 3'd1,
      CMD_SET_COLLAPSED = 3'd2,
      CMD_COLLAPSE_ALL  = 3'd3,
      CMD_RECOUNT       = 3'd4,
      CMD_QUERY         = 3'd5
   } cmd_code_type;

   typedef enum logic [1:0] {
      RD_IDX,
      RD_WALK,
      RD_NODE
   } rd_sel_type;

   typedef enum logic [3:0] {
      WR_NONE,
      WR_CLR_ENTRY,
      WR_PAR,
      WR_COL_NODE,
      WR_COL_IDX,
      WR_DESC_ZERO,
      WR_DESC_INC,
      WR_VIS_ONE,
      WR_VIS_ZERO
   } wr_op_type;

   typedef struct packed {
      logic       accept;
      logic       i_clr;
      logic       i_inc;
      logic       g_clr;
      logic       g_inc;
      logic       w_ld_par;
      logic       w_ld_up;
      rd_sel_type rd_sel;
      wr_op_type  wr_op;
      logic       ok_set;
      logic       q_load;
      logic       cnt_add;
      logic       rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      cmd_code_type cmd;
      logic         node_ok;
      logic         par_ok;
      logic         i_lt_n;
      logic         i_last;
      logic         w_none;
      logic         w_eq_node;
      logic         g_le_n;
      logic         g_lt_n;
      logic         col_differs;
      logic         desc_nz;
      logic         rd_col;
   } dp_sts_type;

endpackage

// ===== rtl/nhvt_datapath.sv =====
// Datapath: node tables, walk pointer, loop and guard counters, result registers.
// Driven by nhvt_ctrl through dp_cmd_type; reports dp_sts_type. Uses nhvt_pkg.
module nhvt_datapath #(
   parameter int MAX_NODES = nhvt_pkg::MAX_NODES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [nhvt_pkg::CFG_W-1:0]      csr_wr_data,
   input  logic [nhvt_pkg::CMD_W-1:0]      req_cmd,
   input  logic [nhvt_pkg::NODE_W-1:0]     req_node,
   input  logic signed [nhvt_pkg::PARENT_W-1:0] req_parent_node,
   input  logic                            req_flag,
   input  nhvt_pkg::dp_cmd_type            cmd,
   output nhvt_pkg::dp_sts_type            sts,
   output logic                            rsp_ok,
   output logic signed [nhvt_pkg::PARENT_W-1:0] rsp_parent_out,
   output logic                            rsp_collapsed_out,
   output logic                            rsp_visible_out,
   output logic [nhvt_pkg::DESC_W-1:0]     rsp_descendants_out,
   output logic [nhvt_pkg::VCOUNT_W-1:0]   rsp_visible_count
);
   import nhvt_pkg::*;

   localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CW = IW + 1;
   localparam int GW = IW + 2;
   localparam int PW = IW + 1;
   localparam int XW = (GW > CFG_W) ? GW : CFG_W;
   localparam logic [XW-1:0] MAX_X = XW'(MAX_NODES);

   // tables
   logic [PW-1:0]     par_mem  [MAX_NODES];
   logic              col_mem  [MAX_NODES];
   logic              vis_mem  [MAX_NODES];
   logic [DESC_W-1:0] desc_mem [MAX_NODES];

   logic [PW-1:0]     rd_par_ff;
   logic              rd_col_ff;
   logic              rd_vis_ff;
   logic [DESC_W-1:0] rd_desc_ff;

   logic [CFG_W-1:0]    node_count_ff;
   cmd_code_type        cmd_ff;
   logic [NODE_W-1:0]   node_ff;
   logic [PARENT_W-1:0] par_ff;
   logic                flag_ff;

   logic [CW-1:0] i_ff, i_in;
   logic [GW-1:0] g_ff, g_in;
   logic          w_none_ff, w_none_in;
   logic [IW-1:0] w_idx_ff, w_idx_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          ok_ff;

   logic [PARENT_W-1:0] q_par_ff;
   logic                q_col_ff;
   logic                q_vis_ff;
   logic [DESC_W-1:0]   q_desc_ff;

   logic [CW-1:0]     n;
   logic [XW-1:0]     n_x;
   logic [XW-1:0]     node_x;
   logic [XW-1:0]     par_x;
   logic              par_neg;
   logic [NODE_W-1:0] par_idx;
   logic [IW-1:0]     node_a;
   logic [IW-1:0]     par_a;
   logic [IW-1:0]     i_a;
   logic              node_ok;
   logic              up_none;
   logic [IW-1:0]     up_idx;

   logic [IW-1:0]     rd_addr;
   logic [IW-1:0]     wr_addr;
   logic              par_we, col_we, vis_we, desc_we;
   logic [PW-1:0]     par_wd;
   logic              col_wd, vis_wd;
   logic [DESC_W-1:0] desc_wd;

   // node_count above the table size acts as the table size
   assign n      = (XW'(node_count_ff) > MAX_X) ? CW'(MAX_X) : CW'(node_count_ff);
   assign n_x    = XW'(n);
   assign node_x = XW'(node_ff);
   assign par_neg = par_ff[PARENT_W-1];
   assign par_idx = par_ff[NODE_W-1:0];
   assign par_x   = XW'(par_idx);
   assign node_a  = IW'(node_ff);
   assign par_a   = IW'(par_idx);
   assign i_a     = i_ff[IW-1:0];
   assign node_ok = node_x < n_x;

   // a stored parent outside the nodes in use ends a walk
   assign up_idx  = rd_par_ff[IW-1:0];
   assign up_none = rd_par_ff[PW-1] || (CW'(up_idx) >= n);

   always_comb begin
      sts.cmd         = cmd_ff;
      sts.node_ok     = node_ok;
      sts.par_ok      = node_ok && (par_neg || ((par_x < n_x) && (par_idx != node_ff)));
      sts.i_lt_n      = i_ff < n;
      sts.i_last      = i_ff == CW'(MAX_NODES - 1);
      sts.w_none      = w_none_ff;
      sts.w_eq_node   = !w_none_ff && (w_idx_ff == node_a);
      sts.g_le_n      = g_ff <= GW'(n);
      sts.g_lt_n      = g_ff < GW'(n);
      sts.col_differs = rd_col_ff != flag_ff;
      sts.desc_nz     = rd_desc_ff != '0;
      sts.rd_col      = rd_col_ff;
   end

   always_comb begin
      unique case (cmd.rd_sel)
         RD_IDX:  rd_addr = i_a;
         RD_WALK: rd_addr = w_idx_ff;
         RD_NODE: rd_addr = node_a;
         default: rd_addr = i_a;
      endcase
   end

   always_comb begin
      wr_addr = i_a;
      par_we  = 1'b0;
      col_we  = 1'b0;
      vis_we  = 1'b0;
      desc_we = 1'b0;
      par_wd  = {1'b1, {IW{1'b0}}};
      col_wd  = 1'b0;
      vis_wd  = 1'b1;
      desc_wd = '0;
      unique case (cmd.wr_op)
         WR_NONE: ;
         WR_CLR_ENTRY: begin
            par_we  = 1'b1;
            col_we  = 1'b1;
            vis_we  = 1'b1;
            desc_we = 1'b1;
         end
         WR_PAR: begin
            wr_addr = node_a;
            par_we  = 1'b1;
            par_wd  = par_neg ? {1'b1, {IW{1'b0}}} : {1'b0, par_a};
         end
         WR_COL_NODE: begin
            wr_addr = node_a;
            col_we  = 1'b1;
            col_wd  = flag_ff;
         end
         WR_COL_IDX: begin
            col_we = 1'b1;
            col_wd = flag_ff;
         end
         WR_DESC_ZERO: desc_we = 1'b1;
         WR_DESC_INC: begin
            wr_addr = w_idx_ff;
            desc_we = 1'b1;
            desc_wd = (rd_desc_ff == DESC_MAX) ? rd_desc_ff : rd_desc_ff + 1'b1;
         end
         WR_VIS_ONE: vis_we = 1'b1;
         WR_VIS_ZERO: begin
            vis_we = 1'b1;
            vis_wd = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (par_we) begin
         par_mem[wr_addr] <= par_wd;
      end
      if (col_we) begin
         col_mem[wr_addr] <= col_wd;
      end
      if (vis_we) begin
         vis_mem[wr_addr] <= vis_wd;
      end
      if (desc_we) begin
         desc_mem[wr_addr] <= desc_wd;
      end
      rd_par_ff  <= par_mem[rd_addr];
      rd_col_ff  <= col_mem[rd_addr];
      rd_vis_ff  <= vis_mem[rd_addr];
      rd_desc_ff <= desc_mem[rd_addr];
   end

   always_comb begin
      i_in = i_ff;
      if (cmd.i_clr) begin
         i_in = '0;
      end else if (cmd.i_inc) begin
         i_in = i_ff + 1'b1;
      end
      g_in = g_ff;
      if (cmd.g_clr) begin
         g_in = '0;
      end else if (cmd.g_inc) begin
         g_in = g_ff + 1'b1;
      end
      w_none_in = w_none_ff;
      w_idx_in  = w_idx_ff;
      if (cmd.w_ld_par) begin
         w_none_in = par_neg;
         w_idx_in  = par_a;
      end else if (cmd.w_ld_up) begin
         w_none_in = up_none;
         w_idx_in  = up_idx;
      end
      cnt_in = cnt_ff;
      if (cmd.accept) begin
         cnt_in = '0;
      end else if (cmd.cnt_add) begin
         cnt_in = cnt_ff + CW'(rd_vis_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= '0;
         i_ff          <= '0;
         ok_ff         <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            node_count_ff <= csr_wr_data;
         end
         i_ff <= i_in;
         if (cmd.accept) begin
            ok_ff <= 1'b0;
         end else if (cmd.ok_set) begin
            ok_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      g_ff      <= g_in;
      w_none_ff <= w_none_in;
      w_idx_ff  <= w_idx_in;
      cnt_ff    <= cnt_in;
      if (cmd.accept) begin
         cmd_ff    <= cmd_code_type'(req_cmd);
         node_ff   <= req_node;
         par_ff    <= req_parent_node;
         flag_ff   <= req_flag;
         q_par_ff  <= '0;
         q_col_ff  <= 1'b0;
         q_vis_ff  <= 1'b0;
         q_desc_ff <= '0;
      end else if (cmd.q_load) begin
         q_par_ff  <= rd_par_ff[PW-1] ? {PARENT_W{1'b1}} : PARENT_W'(up_idx);
         q_col_ff  <= rd_col_ff;
         q_vis_ff  <= rd_vis_ff;
         q_desc_ff <= rd_desc_ff;
      end
      if (cmd.rsp_load) begin
         rsp_ok              <= ok_ff;
         rsp_parent_out      <= q_par_ff;
         rsp_collapsed_out   <= q_col_ff;
         rsp_visible_out     <= q_vis_ff;
         rsp_descendants_out <= q_desc_ff;
         rsp_visible_count   <= VCOUNT_W'(cnt_ff);
      end
   end

endmodule

// ===== rtl/nhvt_ctrl.sv =====
// Sequencer for the node hierarchy visibility table: sweeps, walks and counts.
// Issues dp_cmd_type to nhvt_datapath and reads dp_sts_type. Uses nhvt_pkg.
module nhvt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output nhvt_pkg::dp_cmd_type cmd,
   input  nhvt_pkg::dp_sts_type sts
);
   import nhvt_pkg::*;

   typedef enum logic [4:0] {
      S_INIT,
      S_IDLE,
      S_DISP,
      S_CLR,
      S_SP_CHK,
      S_SP_STEP,
      S_SC_CMP,
      S_CA_RD,
      S_CA_WR,
      S_RC_ZERO,
      S_RC_NODE,
      S_RC_UP,
      S_RC_CHK,
      S_RC_INC,
      S_VIS,
      S_VIS_UP,
      S_VIS_CHK,
      S_VIS_STEP,
      S_Q,
      S_CNT,
      S_CNT_ADD,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = reset || (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.accept   = 1'b0;
      cmd.i_clr    = 1'b0;
      cmd.i_inc    = 1'b0;
      cmd.g_clr    = 1'b0;
      cmd.g_inc    = 1'b0;
      cmd.w_ld_par = 1'b0;
      cmd.w_ld_up  = 1'b0;
      cmd.rd_sel   = RD_IDX;
      cmd.wr_op    = WR_NONE;
      cmd.ok_set   = 1'b0;
      cmd.q_load   = 1'b0;
      cmd.cnt_add  = 1'b0;
      cmd.rsp_load = 1'b0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         S_INIT: begin
            cmd.wr_op = WR_CLR_ENTRY;
            cmd.i_inc = 1'b1;
            if (sts.i_last) begin
               cmd.i_clr = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               cmd.i_clr  = 1'b1;
               state_in   = S_DISP;
            end
         end
         S_DISP: begin
            cmd.g_clr = 1'b1;
            case (sts.cmd)
               CMD_CLEAR: state_in = S_CLR;
               CMD_SET_PARENT: begin
                  if (sts.par_ok) begin
                     cmd.w_ld_par = 1'b1;
                     state_in     = S_SP_CHK;
                  end else begin
                     state_in = S_CNT;
                  end
               end
               CMD_SET_COLLAPSED: begin
                  cmd.rd_sel = RD_NODE;
                  state_in   = sts.node_ok ? S_SC_CMP : S_CNT;
               end
               CMD_COLLAPSE_ALL: begin
                  cmd.ok_set = 1'b1;
                  state_in   = S_CA_RD;
               end
               CMD_RECOUNT: begin
                  cmd.ok_set = 1'b1;
                  state_in   = S_RC_ZERO;
               end
               CMD_QUERY: begin
                  cmd.rd_sel = RD_NODE;
                  state_in   = sts.node_ok ? S_Q : S_CNT;
               end
               default: state_in = S_CNT;
            endcase
         end
         S_CLR: begin
            cmd.wr_op = WR_CLR_ENTRY;
            cmd.i_inc = 1'b1;
            if (sts.i_last) begin
               cmd.i_clr  = 1'b1;
               cmd.ok_set = 1'b1;
               state_in   = S_CNT;
            end
         end
         // walk up from the new parent looking for the child
         S_SP_CHK: begin
            if (sts.w_none || !sts.g_le_n) begin
               cmd.wr_op  = WR_PAR;
               cmd.ok_set = 1'b1;
               state_in   = S_CNT;
            end else if (sts.w_eq_node) begin
               state_in = S_CNT;
            end else begin
               cmd.rd_sel = RD_WALK;
               state_in   = S_SP_STEP;
            end
         end
         S_SP_STEP: begin
            cmd.w_ld_up = 1'b1;
            cmd.g_inc   = 1'b1;
            state_in    = S_SP_CHK;
         end
         S_SC_CMP: begin
            if (sts.col_differs) begin
               cmd.wr_op  = WR_COL_NODE;
               cmd.ok_set = 1'b1;
               state_in   = S_VIS;
            end else begin
               state_in = S_CNT;
            end
         end
         S_CA_RD: begin
            if (sts.i_lt_n) begin
               state_in = S_CA_WR;
            end else begin
               cmd.i_clr = 1'b1;
               state_in  = S_VIS;
            end
         end
         S_CA_WR: begin
            if (sts.desc_nz) begin
               cmd.wr_op = WR_COL_IDX;
            end
            cmd.i_inc = 1'b1;
            state_in  = S_CA_RD;
         end
         S_RC_ZERO: begin
            if (sts.i_lt_n) begin
               cmd.wr_op = WR_DESC_ZERO;
               cmd.i_inc = 1'b1;
            end else begin
               cmd.i_clr = 1'b1;
               state_in  = S_RC_NODE;
            end
         end
         S_RC_NODE: begin
            cmd.g_clr = 1'b1;
            if (sts.i_lt_n) begin
               state_in = S_RC_UP;
            end else begin
               cmd.i_clr = 1'b1;
               state_in  = S_VIS;
            end
         end
         S_RC_UP: begin
            cmd.w_ld_up = 1'b1;
            state_in    = S_RC_CHK;
         end
         S_RC_CHK: begin
            if (sts.w_none || !sts.g_lt_n) begin
               cmd.i_inc = 1'b1;
               state_in  = S_RC_NODE;
            end else begin
               cmd.rd_sel = RD_WALK;
               state_in   = S_RC_INC;
            end
         end
         // bump the ancestor and step past it in the same cycle
         S_RC_INC: begin
            cmd.wr_op   = WR_DESC_INC;
            cmd.w_ld_up = 1'b1;
            cmd.g_inc   = 1'b1;
            state_in    = S_RC_CHK;
         end
         S_VIS: begin
            cmd.g_clr = 1'b1;
            if (sts.i_lt_n) begin
               state_in = S_VIS_UP;
            end else begin
               cmd.i_clr = 1'b1;
               state_in  = S_CNT;
            end
         end
         S_VIS_UP: begin
            cmd.w_ld_up = 1'b1;
            state_in    = S_VIS_CHK;
         end
         S_VIS_CHK: begin
            if (sts.w_none || !sts.g_le_n) begin
               cmd.wr_op = WR_VIS_ONE;
               cmd.i_inc = 1'b1;
               state_in  = S_VIS;
            end else begin
               cmd.rd_sel = RD_WALK;
               state_in   = S_VIS_STEP;
            end
         end
         S_VIS_STEP: begin
            if (sts.rd_col) begin
               cmd.wr_op = WR_VIS_ZERO;
               cmd.i_inc = 1'b1;
               state_in  = S_VIS;
            end else begin
               cmd.w_ld_up = 1'b1;
               cmd.g_inc   = 1'b1;
               state_in    = S_VIS_CHK;
            end
         end
         S_Q: begin
            cmd.q_load = 1'b1;
            cmd.ok_set = 1'b1;
            state_in   = S_CNT;
         end
         S_CNT: begin
            state_in = sts.i_lt_n ? S_CNT_ADD : S_DONE;
         end
         S_CNT_ADD: begin
            cmd.cnt_add = 1'b1;
            cmd.i_inc   = 1'b1;
            state_in    = S_CNT;
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result word overwritten before it was taken");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_DISP))
      else $error("accepted word did not start a command");

   a_parent_checked: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_op == WR_PAR) |-> (sts.par_ok && (sts.cmd == CMD_SET_PARENT)))
      else $error("parent written without passing checks");

   a_walk_has_target: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_sel == RD_WALK) |-> !sts.w_none)
      else $error("walk read issued with no ancestor");

endmodule

// ===== rtl/node_hierarchy_visibility_table.sv =====
// Parent-pointer forest over the first node_count nodes of a MAX_NODES table.
// One command word in, one result word out, one command at a time. After reset,
// and for every clear command, a sweep writes all MAX_NODES entries (no word
// accepted). Every command is accepted, then dispatched, and ends with a
// visible-count pass over the n nodes in use and a load of the result word. Set
// parent walks the chain of ancestors of the new parent. A visibility refresh walks
// each node's ancestors until it meets a collapsed one. Set collapsed, when it
// changes the flag, is one refresh; collapse all adds a sweep over the n nodes
// before it, and recount adds a zeroing pass and a second walk over each node's
// ancestors. The refresh and set-parent walks stop after n+1 steps and the
// recount walk after n; the node tables are read through a single port, one
// ancestor per step.
module node_hierarchy_visibility_table #(
   parameter int MAX_NODES = nhvt_pkg::MAX_NODES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [nhvt_pkg::CFG_W-1:0]           csr_wr_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [nhvt_pkg::CMD_W-1:0]           req_cmd,
   input  logic [nhvt_pkg::NODE_W-1:0]          req_node,
   input  logic signed [nhvt_pkg::PARENT_W-1:0] req_parent_node,
   input  logic                                 req_flag,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_ok,
   output logic signed [nhvt_pkg::PARENT_W-1:0] rsp_parent_out,
   output logic                                 rsp_collapsed_out,
   output logic                                 rsp_visible_out,
   output logic [nhvt_pkg::DESC_W-1:0]          rsp_descendants_out,
   output logic [nhvt_pkg::VCOUNT_W-1:0]        rsp_visible_count
);
   import nhvt_pkg::*;

   dp_cmd_type dp_cmd;
   dp_sts_type dp_sts;

   nhvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (dp_cmd),
      .sts       (dp_sts)
   );

   nhvt_datapath #(
      .MAX_NODES (MAX_NODES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_cmd             (req_cmd),
      .req_node            (req_node),
      .req_parent_node     (req_parent_node),
      .req_flag            (req_flag),
      .cmd                 (dp_cmd),
      .sts                 (dp_sts),
      .rsp_ok              (rsp_ok),
      .rsp_parent_out      (rsp_parent_out),
      .rsp_collapsed_out   (rsp_collapsed_out),
      .rsp_visible_out     (rsp_visible_out),
      .rsp_descendants_out (rsp_descendants_out),
      .rsp_visible_count   (rsp_visible_count)
   );

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for node_hierarchy_visibility_table: a directed table,
// then random commands over many node counts, checked by an in-bench predictor.
// Depends on rtl/nhvt_pkg.sv and rtl/node_hierarchy_visibility_table.sv.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import nhvt_pkg::*;

   localparam logic [CMD_W-1:0] CMD_BAD_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_BAD_7 = 3'd7;
   localparam int NO_CFG = -1;
   localparam int STALL_LIMIT = 4000000;
   localparam int NTAB = MAX_NODES_DEF;
   localparam int RANDOM_ITEMS = 553;

   typedef struct packed {
      logic                       ok;
      logic signed [PARENT_W-1:0] parent;
      logic                       collapsed;
      logic                       visible;
      logic [DESC_W-1:0]          desc;
      logic [VCOUNT_W-1:0]        vcount;
   } tree_result_type;

   typedef struct {
      int               cfg;
      logic [CMD_W-1:0] cmd;
      int               node;
      int               par;
      bit               flag;
      bit               typed;
      tree_result_type  want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [CFG_W-1:0] csr_wr_data;
   logic req_valid, req_stall;
   logic [CMD_W-1:0] req_cmd;
   logic [NODE_W-1:0] req_node;
   logic signed [PARENT_W-1:0] req_parent_node;
   logic req_flag;
   logic rsp_valid, rsp_stall;
   logic rsp_ok, rsp_collapsed_out, rsp_visible_out;
   logic signed [PARENT_W-1:0] rsp_parent_out;
   logic [DESC_W-1:0] rsp_descendants_out;
   logic [VCOUNT_W-1:0] rsp_visible_count;

   node_hierarchy_visibility_table dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic signed [PARENT_W-1:0] parent_tab [NTAB];
   bit                         collapsed_tab [NTAB];
   bit                         visible_tab [NTAB];
   logic [DESC_W-1:0]          desc_tab [NTAB];
   int                         node_count_reg;

   tree_result_type pending_results [$];
   stim_row_type    stim_table [$];
   int errors = 0;
   int idle_pct = 0, stall_pct = 0;
   int long_hold = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   function automatic int nodes_in_use();
      return node_count_reg > NTAB ? NTAB : node_count_reg;
   endfunction

   function automatic int parent_in_use(int i, int n);
      int p;
      p = parent_tab[i];
      if (p < 0 || p >= n) return -1;
      return p;
   endfunction

   function automatic void wipe_forest();
      for (int i = 0; i < NTAB; i++) begin
         parent_tab[i] = -1;
         collapsed_tab[i] = 0;
         visible_tab[i] = 1;
         desc_tab[i] = '0;
      end
   endfunction

   function automatic void refresh_visible();
      int n, p, g;
      bit vis;
      n = nodes_in_use();
      for (int i = 0; i < n; i++) begin
         vis = 1;
         p = parent_in_use(i, n);
         for (g = 0; p >= 0 && g <= n; g++) begin
            if (collapsed_tab[p]) begin
               vis = 0;
               break;
            end
            p = parent_in_use(p, n);
         end
         visible_tab[i] = vis;
      end
   endfunction

   function automatic void count_descendants();
      int n, p, g;
      n = nodes_in_use();
      for (int i = 0; i < n; i++) desc_tab[i] = '0;
      for (int i = 0; i < n; i++) begin
         p = parent_in_use(i, n);
         for (g = 0; p >= 0 && g < n; g++) begin
            if (desc_tab[p] != DESC_MAX) desc_tab[p]++;
            p = parent_in_use(p, n);
         end
      end
   endfunction

   function automatic bit try_reparent(int child, logic [PARENT_W-1:0] raw);
      int n, par, w, g;
      n = nodes_in_use();
      if (child >= n) return 0;
      par = raw[PARENT_W-1] ? -1 : int'(raw[PARENT_W-2:0]);
      if (par >= n) return 0;
      if (par == child) return 0;
      w = par;
      for (g = 0; w >= 0 && g <= n; g++) begin
         if (w == child) return 0;
         w = parent_in_use(w, n);
      end
      parent_tab[child] = PARENT_W'(par);
      return 1;
   endfunction

   function automatic tree_result_type apply_command(logic [CMD_W-1:0] c, int nd,
                                                     logic [PARENT_W-1:0] raw, bit fl);
      tree_result_type r;
      int n, vc;
      r = '0;
      n = nodes_in_use();
      case (c)
         CMD_CLEAR: begin
            wipe_forest();
            r.ok = 1;
         end
         CMD_SET_PARENT: r.ok = try_reparent(nd, raw);
         CMD_SET_COLLAPSED: begin
            if (nd < n && collapsed_tab[nd] != fl) begin
               collapsed_tab[nd] = fl;
               refresh_visible();
               r.ok = 1;
            end
         end
         CMD_COLLAPSE_ALL: begin
            for (int i = 0; i < n; i++)
               if (desc_tab[i] != 0) collapsed_tab[i] = fl;
            refresh_visible();
            r.ok = 1;
         end
         CMD_RECOUNT: begin
            count_descendants();
            refresh_visible();
            r.ok = 1;
         end
         CMD_QUERY: begin
            if (nd < n) begin
               r.ok = 1;
               r.parent = parent_tab[nd];
               r.collapsed = collapsed_tab[nd];
               r.visible = visible_tab[nd];
               r.desc = desc_tab[nd];
            end
         end
         default: ;
      endcase
      vc = 0;
      for (int i = 0; i < n; i++) vc += visible_tab[i];
      r.vcount = VCOUNT_W'(vc);
      return r;
   endfunction

   function automatic tree_result_type mk_res(bit ok, int par, bit col, bit vis, int desc,
                                              int vc);
      tree_result_type r;
      r.ok = ok;
      r.parent = PARENT_W'(par);
      r.collapsed = col;
      r.visible = vis;
      r.desc = DESC_W'(desc);
      r.vcount = VCOUNT_W'(vc);
      return r;
   endfunction

   function automatic void add_row(int cfg, logic [CMD_W-1:0] c, int nd, int par, bit fl,
                                   bit typed = 0, tree_result_type want = '0);
      stim_row_type s;
      s.cfg = cfg;
      s.cmd = c;
      s.node = nd;
      s.par = par;
      s.flag = fl;
      s.typed = typed;
      s.want = want;
      stim_table.push_back(s);
   endfunction

   task automatic send_word(logic [CMD_W-1:0] c, int nd, int par, bit fl, bit typed,
                            tree_result_type want);
      tree_result_type got;
      logic [PARENT_W-1:0] raw;
      int gap;
      raw = par[PARENT_W-1:0];
      req_valid <= 1'b1;
      req_cmd <= c;
      req_node <= nd[NODE_W-1:0];
      req_parent_node <= raw;
      req_flag <= fl;
      do @(posedge clock); while (req_stall);
      got = apply_command(c, nd[NODE_W-1:0], raw, fl);
      pending_results.push_back(typed ? want : got);
      gap = 0;
      while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // drain, let the block settle, then write the node count
   task automatic write_node_count(int value);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value[CFG_W-1:0];
      @(posedge clock);
      node_count_reg = value & 'h7FF;
      csr_wr_en <= 1'b0;
   endtask

   // receiver: random stall, or a long counted hold-off on request
   always @(posedge clock) begin
      if (long_hold > 0) begin
         hold_left = long_hold;
         long_hold = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // compare each result word with the oldest prediction
   always @(posedge clock) begin
      tree_result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result word with nothing expected");
            errors++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_ok !== exp_r.ok) begin
               $error("ok: expected %0d, got %0d", exp_r.ok, rsp_ok);
               errors++;
            end
            if (rsp_parent_out !== exp_r.parent) begin
               $error("parent_out: expected %0d, got %0d", exp_r.parent, rsp_parent_out);
               errors++;
            end
            if (rsp_collapsed_out !== exp_r.collapsed) begin
               $error("collapsed_out: expected %0d, got %0d", exp_r.collapsed,
                      rsp_collapsed_out);
               errors++;
            end
            if (rsp_visible_out !== exp_r.visible) begin
               $error("visible_out: expected %0d, got %0d", exp_r.visible, rsp_visible_out);
               errors++;
            end
            if (rsp_descendants_out !== exp_r.desc) begin
               $error("descendants_out: expected %0d, got %0d", exp_r.desc,
                      rsp_descendants_out);
               errors++;
            end
            if (rsp_visible_count !== exp_r.vcount) begin
               $error("visible_count: expected %0d, got %0d", exp_r.vcount,
                      rsp_visible_count);
               errors++;
            end
         end
      end
   end

   // watchdog: too long with no word moving on either side
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   initial begin
      int n_eff, batch, items, sent, r, nd, par;
      logic [CMD_W-1:0] c;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      req_valid <= 1'b0;
      req_cmd <= CMD_CLEAR;
      req_node <= '0;
      req_parent_node <= '0;
      req_flag <= 1'b0;
      node_count_reg = 0;
      wipe_forest();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table first, then a small forest, then the widest
      add_row(NO_CFG, CMD_QUERY, 0, 0, 0, 1, mk_res(0, 0, 0, 0, 0, 0));
      add_row(NO_CFG, CMD_BAD_6, 5, 3, 1, 1, mk_res(0, 0, 0, 0, 0, 0));
      add_row(NO_CFG, CMD_BAD_7, 1023, 1023, 1, 1, mk_res(0, 0, 0, 0, 0, 0));
      add_row(NO_CFG, CMD_SET_PARENT, 0, 0, 0, 1, mk_res(0, 0, 0, 0, 0, 0));
      add_row(8, CMD_QUERY, 7, 0, 0, 1, mk_res(1, -1, 0, 1, 0, 8));
      add_row(NO_CFG, CMD_QUERY, 8, 0, 0, 1, mk_res(0, 0, 0, 0, 0, 8));
      add_row(NO_CFG, CMD_SET_PARENT, 1, 0, 0, 1, mk_res(1, 0, 0, 0, 0, 8));
      add_row(NO_CFG, CMD_SET_PARENT, 0, 0, 0, 1, mk_res(0, 0, 0, 0, 0, 8));
      add_row(NO_CFG, CMD_SET_PARENT, 0, 1, 0, 1, mk_res(0, 0, 0, 0, 0, 8));
      add_row(NO_CFG, CMD_SET_PARENT, 2, 1, 0);
      add_row(NO_CFG, CMD_SET_PARENT, 3, 2, 0);
      add_row(NO_CFG, CMD_SET_PARENT, 4, 1023, 0, 1, mk_res(0, 0, 0, 0, 0, 8));
      add_row(NO_CFG, CMD_SET_PARENT, 3, -1024, 1);
      add_row(NO_CFG, CMD_SET_COLLAPSED, 1, 0, 1);
      add_row(NO_CFG, CMD_SET_COLLAPSED, 1, 0, 1);
      add_row(NO_CFG, CMD_RECOUNT, 0, 0, 0);
      add_row(NO_CFG, CMD_QUERY, 0, 0, 0);
      add_row(NO_CFG, CMD_COLLAPSE_ALL, 0, 0, 0);
      add_row(NO_CFG, CMD_COLLAPSE_ALL, 0, 0, 1);
      add_row(NO_CFG, CMD_QUERY, 2, 0, 0);
      add_row(NO_CFG, CMD_CLEAR, 0, 0, 0, 1, mk_res(1, 0, 0, 0, 0, 8));
      add_row(2047, CMD_QUERY, 1023, 0, 0, 1, mk_res(1, -1, 0, 1, 0, 1024));
      add_row(NO_CFG, CMD_SET_PARENT, 1023, 0, 0);
      add_row(NO_CFG, CMD_RECOUNT, 0, 0, 0);
      add_row(NO_CFG, CMD_QUERY, 0, 0, 0);
      // shrink: node 1023 is now out of use but keeps its stale parent
      add_row(3, CMD_QUERY, 0, 0, 0);
      add_row(NO_CFG, CMD_CLEAR, 0, 0, 0);

      foreach (stim_table[i]) begin
         if (stim_table[i].cfg != NO_CFG) write_node_count(stim_table[i].cfg);
         send_word(stim_table[i].cmd, stim_table[i].node, stim_table[i].par,
                   stim_table[i].flag, stim_table[i].typed, stim_table[i].want);
      end

      sent = 0;
      batch = 0;
      while (sent < RANDOM_ITEMS) begin
         r = $urandom_range(99);
         if (r < 6) write_node_count(0);
         else if (r < 10) write_node_count($urandom_range(1) ? 1024 : 2047);
         else if (r < 13) write_node_count($urandom_range(1025, 2046));
         else write_node_count($urandom_range(1, 40));
         n_eff = nodes_in_use();
         case (batch % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 70; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 70; end
            default: begin idle_pct = 32; stall_pct = 32; end
         endcase
         // fill the block behind a long receiver hold-off
         if (batch == 2) long_hold = 400;
         items = (n_eff > 40) ? 8 : 40;
         if (items > RANDOM_ITEMS - sent) items = RANDOM_ITEMS - sent;
         for (int k = 0; k < items; k++) begin
            r = $urandom_range(99);
            if (r < 35) c = CMD_SET_PARENT;
            else if (r < 50) c = CMD_SET_COLLAPSED;
            else if (r < 58) c = CMD_COLLAPSE_ALL;
            else if (r < 70) c = CMD_RECOUNT;
            else if (r < 95) c = CMD_QUERY;
            else if (r < 97) c = CMD_CLEAR;
            else c = $urandom_range(1) ? CMD_BAD_6 : CMD_BAD_7;
            nd = ($urandom_range(9) < 8) ? $urandom_range(0, (n_eff + 1 > 1023) ? 1023 : n_eff + 1)
                                         : $urandom_range(0, 1023);
            r = $urandom_range(9);
            if (r == 0) par = -$urandom_range(1, 1024);
            else if (r == 1) par = $urandom_range(0, 1023);
            else par = $urandom_range(0, n_eff > 1023 ? 1023 : n_eff);
            send_word(c, nd, par, $urandom_range(1), 0, '0);
         end
         sent += items;
         batch++;
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end
endmodule
